// ===== rtl/aat_pkg.sv =====
// Shared types and constants for the box affine transform block.
// No dependencies; every other file in this folder imports this package.
`default_nettype none

package aat_pkg;

  // Field widths and fixed-point formats
  localparam int COORD_W   = 24;               // signed Q16.8 coordinate
  localparam int COEF_W    = 16;               // signed Q4.12 coefficient
  localparam int COEF_FRAC = 12;
  localparam int AXES      = 3;
  localparam int LIN_W     = AXES * COEF_W;    // one packed matrix row
  localparam int CFG_W     = (LIN_W > COORD_W) ? LIN_W : COORD_W;
  localparam int CFG_IDX_W = 3;

  // Arithmetic widths in the back end
  localparam int PROD_W = COEF_W + COORD_W;
  localparam int SUM_W  = PROD_W + 2;          // three products
  localparam int SHR_W  = SUM_W - COEF_FRAC;
  localparam int ADD_W  = ((SHR_W > COORD_W) ? SHR_W : COORD_W) + 1;

  // Stream word widths
  localparam int IN_DATA_W  = 2 * AXES * COORD_W;
  localparam int OUT_DATA_W = 2 * AXES * COORD_W;

  // Queue between front and back; depth must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Z = 3'd5;

  // Saturation limits, also the empty box corners
  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Identity coefficient (1.0 in Q4.12)
  localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

  // One box as it travels from front to back; index 0 is x
  typedef struct packed {
    logic                          box_ok;
    logic [AXES-1:0][COORD_W-1:0]  hi;
    logic [AXES-1:0][COORD_W-1:0]  lo;
  } item_t;

  // Matrix and translation as seen by the back end
  typedef struct packed {
    logic [AXES-1:0][LIN_W-1:0]    row;
    logic [AXES-1:0][COORD_W-1:0]  shift;
  } xform_t;

  // Queue status toward the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/aat_front.sv =====
// Front end: takes input words, checks the box for inversion, hands it to the queue.
// Depends on aat_pkg.
`default_nettype none

module aat_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [aat_pkg::IN_DATA_W-1:0] s_axis_tdata, // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  input  wire aat_pkg::queue_status_t      q_status_i,
  output logic                             push_o,
  output aat_pkg::item_t                   item_o
);
  import aat_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  item_t item_d;
  logic  take;

  // Classify the incoming word: any axis with lo above hi makes the box empty
  always_comb begin
    item_d.lo     = s_axis_tdata[AXES*COORD_W-1:0];
    item_d.hi     = s_axis_tdata[2*AXES*COORD_W-1:AXES*COORD_W];
    item_d.box_ok = 1'b1;
    for (int a = 0; a < AXES; a++) begin
      if ($signed(item_d.lo[a]) > $signed(item_d.hi[a])) begin
        item_d.box_ok = 1'b0;
      end
    end
  end

  // Hold one word; accept a new one whenever the slot is empty or its word can move on this cycle
  assign push_o        = valid_q && !q_status_i.full;
  assign s_axis_tready = !valid_q || !q_status_i.full;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign item_o        = item_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aat_queue.sv =====
// Short queue of boxes between the front and back ends.
// Depends on aat_pkg.
`default_nettype none

module aat_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire aat_pkg::item_t     item_i,
  input  wire logic               pop_i,
  output aat_pkg::item_t          head_o,
  output aat_pkg::queue_status_t  status_o
);
  import aat_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;
  logic                do_push, do_pop;

  assign status_o.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  // Advance pointers; they wrap at the power-of-two depth
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aat_back.sv =====
// Back end: multiply, sum, translate and saturate, then the output register.
// Depends on aat_pkg.
`default_nettype none

module aat_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire aat_pkg::xform_t                xform_i,
  input  wire aat_pkg::item_t                 head_i,
  input  wire aat_pkg::queue_status_t         q_status_i,
  output logic                                pop_o,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [aat_pkg::OUT_DATA_W-1:0]      m_axis_tdata, // out_lo_x..z, out_hi_x..z
  output logic                                m_axis_tuser  // box_valid
);
  import aat_pkg::*;

  // Clamp a wide signed value to the coordinate range
  function automatic logic [COORD_W-1:0] sat_coord(input logic [ADD_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v[ADD_W-1:COORD_W-1] == '0 || v[ADD_W-1:COORD_W-1] == '1) begin
      r = v[COORD_W-1:0];
    end else begin
      r = v[ADD_W-1] ? COORD_MIN : COORD_MAX;
    end
    return r;
  endfunction

  // Stage control
  logic mul_valid_q, sum_valid_q, out_valid_q;
  logic out_adv, sum_adv, mul_adv;

  assign out_adv = !out_valid_q || m_axis_tready;
  assign sum_adv = !sum_valid_q || out_adv;
  assign mul_adv = !mul_valid_q || sum_adv;
  assign pop_o   = !q_status_i.empty && mul_adv;

  // Payload registers
  logic signed [PROD_W-1:0] prod_lo_q [AXES][AXES];
  logic signed [PROD_W-1:0] prod_hi_q [AXES][AXES];
  logic signed [PROD_W-1:0] prod_lo_d [AXES][AXES];
  logic signed [PROD_W-1:0] prod_hi_d [AXES][AXES];
  logic                     mul_ok_q;
  logic signed [SUM_W-1:0]  sum_lo_q [AXES];
  logic signed [SUM_W-1:0]  sum_hi_q [AXES];
  logic signed [SUM_W-1:0]  sum_lo_d [AXES];
  logic signed [SUM_W-1:0]  sum_hi_d [AXES];
  logic                     sum_ok_q;
  logic [AXES-1:0][COORD_W-1:0] out_lo_q, out_hi_q, out_lo_d, out_hi_d;
  logic                     out_ok_q;

  // Per term, a negative coefficient takes its minimum at the box maximum
  always_comb begin
    logic signed [COEF_W-1:0]  c;
    logic signed [COORD_W-1:0] op_lo, op_hi;
    for (int a = 0; a < AXES; a++) begin
      for (int j = 0; j < AXES; j++) begin
        c     = $signed(xform_i.row[a][(AXES-1-j)*COEF_W +: COEF_W]);
        op_lo = c[COEF_W-1] ? $signed(head_i.hi[j]) : $signed(head_i.lo[j]);
        op_hi = c[COEF_W-1] ? $signed(head_i.lo[j]) : $signed(head_i.hi[j]);
        prod_lo_d[a][j] = PROD_W'(c) * PROD_W'(op_lo);
        prod_hi_d[a][j] = PROD_W'(c) * PROD_W'(op_hi);
      end
    end
  end

  // Sum the three terms of each output axis
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_lo_d[a] = SUM_W'(prod_lo_q[a][0]) + SUM_W'(prod_lo_q[a][1])
                  + SUM_W'(prod_lo_q[a][2]);
      sum_hi_d[a] = SUM_W'(prod_hi_q[a][0]) + SUM_W'(prod_hi_q[a][1])
                  + SUM_W'(prod_hi_q[a][2]);
    end
  end

  // Drop the fraction, add the translation, saturate; empty box when inverted
  always_comb begin
    logic signed [SHR_W-1:0] shr_lo, shr_hi;
    logic signed [ADD_W-1:0] sh;
    for (int a = 0; a < AXES; a++) begin
      shr_lo = sum_lo_q[a][SUM_W-1:COEF_FRAC];
      shr_hi = sum_hi_q[a][SUM_W-1:COEF_FRAC];
      sh     = ADD_W'($signed(xform_i.shift[a]));
      if (sum_ok_q) begin
        out_lo_d[a] = sat_coord(ADD_W'(shr_lo) + sh);
        out_hi_d[a] = sat_coord(ADD_W'(shr_hi) + sh);
      end else begin
        out_lo_d[a] = COORD_MAX;
        out_hi_d[a] = COORD_MIN;
      end
    end
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mul_adv) begin
        mul_valid_q <= pop_o;
      end
      if (sum_adv) begin
        sum_valid_q <= mul_valid_q;
      end
      if (out_adv) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
      mul_ok_q  <= head_i.box_ok;
    end
    if (sum_adv && mul_valid_q) begin
      sum_lo_q <= sum_lo_d;
      sum_hi_q <= sum_hi_d;
      sum_ok_q <= mul_ok_q;
    end
    if (out_adv && sum_valid_q) begin
      out_lo_q <= out_lo_d;
      out_hi_q <= out_hi_d;
      out_ok_q <= sum_ok_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_hi_q, out_lo_q};
  assign m_axis_tuser  = out_ok_q;

endmodule

`default_nettype wire

// ===== rtl/aabb_affine_transform.sv =====
// Top level of the box affine transform: matrix registers, front, queue, back.
// Depends on aat_pkg, aat_front, aat_queue and aat_back.
`default_nettype none

// Maps an axis-aligned box (signed Q16.8 corners) through a 3x4 affine matrix
// (Q4.12 linear part, Q16.8 translation) and returns the box enclosing the eight
// mapped corners, each coordinate saturated to 24 bits. Because the map is
// linear per term, the enclosing box is built from nine coefficient terms, each
// evaluated at the box end that gives its minimum and its maximum, so eighteen
// 16x24 multipliers work in parallel. One box is accepted every cycle, also while a
// result waits, unless the front register and the queue are both full. A box passes
// the front register, queue, multiply, sum and translate/saturate output register.
// A four-entry queue separates the front from the back. An inverted box (lo above
// hi on any axis) returns the empty box with box_valid low. Write the matrix only
// while no box is in flight.
module aabb_affine_transform (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [aat_pkg::IN_DATA_W-1:0]    s_axis_tdata, // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  // Output stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [aat_pkg::OUT_DATA_W-1:0]        m_axis_tdata, // out_lo_x..z, out_hi_x..z
  output logic                                  m_axis_tuser, // box_valid
  // Configuration writes
  input  wire logic                             cfg_we_i,
  input  wire logic [aat_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [aat_pkg::CFG_W-1:0]        cfg_data_i
);
  import aat_pkg::*;

  xform_t        xform_q;
  item_t         front_item;
  item_t         head_item;
  queue_status_t q_status;
  logic          push, pop;

  // Matrix and translation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xform_q.row[0]   <= LIN_W'(COEF_ONE) << (2 * COEF_W);
      xform_q.row[1]   <= LIN_W'(COEF_ONE) << COEF_W;
      xform_q.row[2]   <= LIN_W'(COEF_ONE);
      xform_q.shift    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROW_X:   xform_q.row[0]   <= cfg_data_i[LIN_W-1:0];
        REG_ROW_Y:   xform_q.row[1]   <= cfg_data_i[LIN_W-1:0];
        REG_ROW_Z:   xform_q.row[2]   <= cfg_data_i[LIN_W-1:0];
        REG_SHIFT_X: xform_q.shift[0] <= cfg_data_i[COORD_W-1:0];
        REG_SHIFT_Y: xform_q.shift[1] <= cfg_data_i[COORD_W-1:0];
        REG_SHIFT_Z: xform_q.shift[2] <= cfg_data_i[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  aat_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .q_status_i   (q_status),
    .push_o       (push),
    .item_o       (front_item)
  );

  aat_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .head_o  (head_item),
    .status_o(q_status)
  );

  aat_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .xform_i      (xform_q),
    .head_i       (head_item),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // A valid result box is never inverted on x
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      $signed(m_axis_tdata[COORD_W-1:0]) <= $signed(m_axis_tdata[4*COORD_W-1:3*COORD_W]))
    else $error("valid output box has min x above max x");

  // An empty result carries the empty box corners
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[COORD_W-1:0] == COORD_MAX &&
      m_axis_tdata[4*COORD_W-1:3*COORD_W] == COORD_MIN)
    else $error("empty output box has wrong corners");

  // The front never pushes into a full queue, and the back never pops an empty one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full) && !(pop && q_status.empty))
    else $error("queue overflow or underflow");

endmodule

`default_nettype wire

// ===== tb/tb_aabb_affine_transform.sv =====
// Self-checking testbench for the box affine transform (aabb_affine_transform).
// Depends on aat_pkg and the RTL top; predicts each result box from its own model.
`default_nettype none

module tb_aabb_affine_transform;
  timeunit 1ns;
  timeprecision 1ps;

  import aat_pkg::*;

  // Coordinate range as plain integers
  localparam int COORD_TOP    = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_BOTTOM = -COORD_TOP - 1;

  // Register indexes past the last register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // Coefficient extremes in Q4.12
  localparam logic [COEF_W-1:0] COEF_MOST_POS = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_MOST_NEG = 16'h8000;

  // One box; lo_x sits in the lowest bits of the word
  typedef struct packed {
    logic [COORD_W-1:0] hi_z;
    logic [COORD_W-1:0] hi_y;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] lo_z;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] lo_x;
  } box_t;

  typedef struct packed {
    logic ok;
    box_t box;
  } bbox_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [IN_DATA_W-1:0]  in_word = '0;     // lo_x, lo_y, lo_z, hi_x, hi_y, hi_z
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_DATA_W-1:0] out_word;         // out_lo_x..z, out_hi_x..z
  logic                  out_flag;         // box_valid
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Predictor copy of the matrix registers, reset values included
  logic [LIN_W-1:0]   lin_rows [AXES];
  logic [COORD_W-1:0] offsets  [AXES];

  bbox_result_t expected_boxes[$];

  int mismatches    = 0;
  int n_sent        = 0;
  int n_checked     = 0;
  int n_empty       = 0;
  int n_writes      = 0;
  int input_stalls  = 0;
  int stall_left    = 0;
  int hold_cycles   = 0;
  bit src_gaps      = 1'b0;
  bit sink_stalls   = 1'b0;

  aabb_affine_transform u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (in_ready),
    .s_axis_tdata  (in_word),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_word),
    .m_axis_tuser  (out_flag),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always #1 clk = ~clk;

  // Run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint coef_at(logic [LIN_W-1:0] row, int slot);
    logic signed [COEF_W-1:0] c;
    c = row[slot*COEF_W +: COEF_W];
    return longint'(c);
  endfunction

  // One output axis of one corner: floor(sum / 2^12) + offset, saturated
  function automatic longint map_axis(int axis, longint x, longint y, longint z);
    longint acc;
    longint v;
    logic signed [COORD_W-1:0] off;
    acc = coef_at(lin_rows[axis], 2) * x + coef_at(lin_rows[axis], 1) * y
        + coef_at(lin_rows[axis], 0) * z;
    off = offsets[axis];
    v = (acc >>> COEF_FRAC) + longint'(off);
    if (v > COORD_TOP) v = COORD_TOP;
    if (v < COORD_BOTTOM) v = COORD_BOTTOM;
    return v;
  endfunction

  // Enclosing box of the eight mapped corners; empty box for an inverted input
  function automatic bbox_result_t enclose_mapped_box(box_t b);
    bbox_result_t res;
    longint lo [AXES];
    longint hi [AXES];
    longint mn [AXES];
    longint mx [AXES];
    longint px, py, pz, pt;
    int a, c;
    lo[0] = $signed(b.lo_x);
    lo[1] = $signed(b.lo_y);
    lo[2] = $signed(b.lo_z);
    hi[0] = $signed(b.hi_x);
    hi[1] = $signed(b.hi_y);
    hi[2] = $signed(b.hi_z);
    res.ok = 1'b1;
    for (a = 0; a < AXES; a++) begin
      if (lo[a] > hi[a]) res.ok = 1'b0;
      mn[a] = COORD_TOP;
      mx[a] = COORD_BOTTOM;
    end
    if (res.ok) begin
      for (c = 0; c < 8; c++) begin
        px = ((c & 1) != 0) ? hi[0] : lo[0];
        py = ((c & 2) != 0) ? hi[1] : lo[1];
        pz = ((c & 4) != 0) ? hi[2] : lo[2];
        for (a = 0; a < AXES; a++) begin
          pt = map_axis(a, px, py, pz);
          if (pt < mn[a]) mn[a] = pt;
          if (pt > mx[a]) mx[a] = pt;
        end
      end
    end
    res.box.lo_x = mn[0][COORD_W-1:0];
    res.box.lo_y = mn[1][COORD_W-1:0];
    res.box.lo_z = mn[2][COORD_W-1:0];
    res.box.hi_x = mx[0][COORD_W-1:0];
    res.box.hi_y = mx[1][COORD_W-1:0];
    res.box.hi_z = mx[2][COORD_W-1:0];
    return res;
  endfunction

  // ------------------------------------------------------------------ helpers

  function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.lo_x = lx[COORD_W-1:0];
    b.lo_y = ly[COORD_W-1:0];
    b.lo_z = lz[COORD_W-1:0];
    b.hi_x = hx[COORD_W-1:0];
    b.hi_y = hy[COORD_W-1:0];
    b.hi_z = hz[COORD_W-1:0];
    return b;
  endfunction

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_gap();
    if (!src_gaps || $urandom_range(0, 99) < 55) return 0;
    return idle_length();
  endfunction

  function automatic int rand_coord();
    int unsigned r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 40) v = int'($urandom_range(0, 32767)) - 16384;
    else if (r < 70) v = int'($urandom_range(0, 1048575)) - 524288;
    else if (r < 76) v = COORD_TOP;
    else if (r < 82) v = COORD_BOTTOM;
    else begin
      v = $urandom;
      v = $signed(v[COORD_W-1:0]);
    end
    return v;
  endfunction

  // Mostly well-formed boxes, some inverted ones, some raw noise
  function automatic box_t rand_box();
    int lo [AXES];
    int hi [AXES];
    int a, t, bad;
    int unsigned r;
    for (a = 0; a < AXES; a++) begin
      lo[a] = rand_coord();
      hi[a] = ($urandom_range(0, 9) == 0) ? lo[a] : rand_coord();
    end
    r = $urandom_range(0, 99);
    if (r < 92) begin
      for (a = 0; a < AXES; a++) begin
        if (lo[a] > hi[a]) begin
          t = lo[a];
          lo[a] = hi[a];
          hi[a] = t;
        end
      end
    end
    if (r >= 80 && r < 92) begin
      // invert one axis, by one step now and then
      bad = $urandom_range(0, AXES - 1);
      if (lo[bad] == hi[bad] || $urandom_range(0, 3) == 0) begin
        if (hi[bad] != COORD_TOP) begin
          lo[bad] = hi[bad] + 1;
        end else begin
          lo[bad] = hi[bad];
          hi[bad] = hi[bad] - 1;
        end
      end else begin
        t = lo[bad];
        lo[bad] = hi[bad];
        hi[bad] = t;
      end
    end
    return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    int unsigned r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 50) v = int'($urandom_range(0, 8192)) - 4096;
    else if (r < 75) v = $urandom;
    else if (r < 85) return COEF_MOST_NEG;
    else if (r < 95) return COEF_MOST_POS;
    else v = 0;
    return v[COEF_W-1:0];
  endfunction

  function automatic int rand_offset();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return int'($urandom_range(0, 8191)) - 4096;
    if (r < 80) return $signed(24'($urandom));
    if (r < 90) return COORD_TOP;
    return COORD_BOTTOM;
  endfunction

  function automatic logic [LIN_W-1:0] row_of(logic [COEF_W-1:0] cx, logic [COEF_W-1:0] cy,
                                               logic [COEF_W-1:0] cz);
    return {cx, cy, cz};
  endfunction

  // --------------------------------------------------------- stimulus tasks

  // Write one register at a falling edge; bits past its width carry junk
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    n_writes++;
    case (idx)
      REG_ROW_X:   lin_rows[0] = data[LIN_W-1:0];
      REG_ROW_Y:   lin_rows[1] = data[LIN_W-1:0];
      REG_ROW_Z:   lin_rows[2] = data[LIN_W-1:0];
      REG_SHIFT_X: offsets[0]  = data[COORD_W-1:0];
      REG_SHIFT_Y: offsets[1]  = data[COORD_W-1:0];
      REG_SHIFT_Z: offsets[2]  = data[COORD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_matrix(logic [LIN_W-1:0] rx, logic [LIN_W-1:0] ry, logic [LIN_W-1:0] rz,
                             int ox, int oy, int oz);
    logic [CFG_W-COORD_W-1:0] junk;
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    junk = (CFG_W-COORD_W)'($urandom);
    write_reg(REG_SHIFT_X, {junk, ox[COORD_W-1:0]});
    junk = (CFG_W-COORD_W)'($urandom);
    write_reg(REG_SHIFT_Y, {junk, oy[COORD_W-1:0]});
    junk = (CFG_W-COORD_W)'($urandom);
    write_reg(REG_SHIFT_Z, {junk, oz[COORD_W-1:0]});
  endtask

  // Offer one box after an optional gap; hold it until the block takes it
  task automatic send_box(box_t b, int gap);
    bbox_result_t res;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= b;
    do @(posedge clk); while (!in_ready);
    res = enclose_mapped_box(b);
    expected_boxes.push_back(res);
    n_sent++;
    if (!res.ok) n_empty++;
  endtask

  // Drop valid, wait for every pending result, then let the pipe settle
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_boxes.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (16) @(posedge clk);
  endtask

  // ------------------------------------------------------------------- tests

  // Identity matrix from reset: extremes, degenerate and inverted boxes
  task automatic test_reset_identity();
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    send_box(mk_box(0, 0, 0, 0, 0, 0), 0);
    send_box(mk_box(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP, COORD_TOP, COORD_TOP), 0);
    send_box(mk_box(256, -512, 1000, 256, -512, 1000), 0);
    send_box(mk_box(-5592406, -5592406, -5592406, 5592405, 5592405, 5592405), 1);
    send_box(mk_box(1, 0, 0, 0, 0, 0), 0);
    send_box(mk_box(0, 1, 0, 0, 0, 0), 0);
    send_box(mk_box(0, 0, 1, 0, 0, 0), 2);
    send_box(mk_box(COORD_TOP, COORD_TOP, COORD_TOP, COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM), 0);
    send_box(mk_box(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP), 0);
    send_box(mk_box(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM,
                    COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM), 0);
    drain();
  endtask

  // Largest and smallest coefficients and offsets, axis swap, ignored indexes
  task automatic test_register_extremes();
    load_matrix(row_of(COEF_MOST_POS, COEF_MOST_POS, COEF_MOST_POS),
                row_of(COEF_MOST_POS, COEF_MOST_POS, COEF_MOST_POS),
                row_of(COEF_MOST_POS, COEF_MOST_POS, COEF_MOST_POS),
                COORD_TOP, COORD_TOP, COORD_TOP);
    send_box(mk_box(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP, COORD_TOP, COORD_TOP), 0);
    send_box(mk_box(0, 0, 0, 0, 0, 0), 0);
    send_box(mk_box(-300, -20, 7, 45, 900, 7), 0);
    drain();

    load_matrix(row_of(COEF_MOST_NEG, COEF_MOST_NEG, COEF_MOST_NEG),
                row_of(COEF_MOST_NEG, COEF_MOST_NEG, COEF_MOST_NEG),
                row_of(COEF_MOST_NEG, COEF_MOST_NEG, COEF_MOST_NEG),
                COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM);
    send_box(mk_box(COORD_BOTTOM, COORD_BOTTOM, COORD_BOTTOM, COORD_TOP, COORD_TOP, COORD_TOP), 0);
    send_box(mk_box(0, 0, 0, 0, 0, 0), 0);
    send_box(mk_box(-1, -1, -1, 1, 1, 1), 0);
    drain();

    // rotate axes with a sign flip, then poke the unused indexes
    load_matrix(row_of('0, -COEF_ONE, '0), row_of('0, '0, COEF_ONE),
                row_of(COEF_ONE, '0, '0), 256, -4096, 8388000);
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    send_box(mk_box(-1000, 50, -70000, 2000, 51, 90000), 0);
    send_box(mk_box(COORD_BOTTOM, 3, COORD_BOTTOM, 3, 3, COORD_TOP), 0);
    drain();
  endtask

  // Random boxes under several random matrices and idle patterns
  task automatic test_random_phases();
    int p, i;
    for (p = 0; p < 6; p++) begin
      load_matrix(row_of(rand_coef(), rand_coef(), rand_coef()),
                  row_of(rand_coef(), rand_coef(), rand_coef()),
                  row_of(rand_coef(), rand_coef(), rand_coef()),
                  rand_offset(), rand_offset(), rand_offset());
      if ($urandom_range(0, 1) == 1)
        write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_6 : REG_SPARE_7,
                  CFG_W'({$urandom, $urandom}));
      src_gaps    = (p == 1 || p == 2 || p >= 4);
      sink_stalls = (p == 1 || p == 3 || p >= 4);
      for (i = 0; i < 135; i++) send_box(rand_box(), next_gap());
      drain();
    end
  endtask

  // Hold the output off long enough that the input stalls, then drain fully
  task automatic test_backpressure();
    int i;
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    @(posedge clk);
    hold_cycles = 300;
    for (i = 0; i < 40; i++) send_box(rand_box(), 0);
    drain();
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
    for (i = 0; i < 20; i++) send_box(rand_box(), next_gap());
    drain();
  endtask

  // ----------------------------------------------------------- output side

  // Drive ready at the falling edge: long hold first, then random stalls
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (sink_stalls && $urandom_range(0, 99) < 15) begin
      stall_left = idle_length() - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic string coord_name(int i);
    case (i)
      0: return "out_lo_x";
      1: return "out_lo_y";
      2: return "out_lo_z";
      3: return "out_hi_x";
      4: return "out_hi_y";
      default: return "out_hi_z";
    endcase
  endfunction

  task automatic flag_mismatch(string what, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t ns: mismatch on %s, expected %h, got %h", $time, what, want, got);
  endtask

  // Compare each accepted word with the oldest prediction
  always @(posedge clk) begin
    bbox_result_t want;
    logic [OUT_DATA_W-1:0] want_word;
    int i;
    if (rst_n && in_valid && !in_ready) input_stalls++;
    if (rst_n && out_valid && out_ready) begin
      if (expected_boxes.size() == 0) begin
        flag_mismatch("unexpected word", '0, out_word[COORD_W-1:0]);
      end else begin
        want = expected_boxes.pop_front();
        want_word = want.box;
        n_checked++;
        for (i = 0; i < 2 * AXES; i++) begin
          if (out_word[i*COORD_W +: COORD_W] !== want_word[i*COORD_W +: COORD_W])
            flag_mismatch(coord_name(i), want_word[i*COORD_W +: COORD_W],
                          out_word[i*COORD_W +: COORD_W]);
        end
        if (out_flag !== want.ok)
          flag_mismatch("box_valid", COORD_W'(want.ok), COORD_W'(out_flag));
      end
    end
  end

  // -------------------------------------------------------------- sequence

  initial begin
    lin_rows[0] = row_of(COEF_ONE, '0, '0);
    lin_rows[1] = row_of('0, COEF_ONE, '0);
    lin_rows[2] = row_of('0, '0, COEF_ONE);
    offsets[0]  = '0;
    offsets[1]  = '0;
    offsets[2]  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(negedge clk);

    test_reset_identity();
    test_register_extremes();
    test_random_phases();
    test_backpressure();

    if (expected_boxes.size() != 0) begin
      mismatches += expected_boxes.size();
      $display("%0d predicted words never arrived", expected_boxes.size());
    end
    $display("Sent %0d boxes (%0d inverted) under %0d register writes; checked %0d words.",
             n_sent, n_empty, n_writes, n_checked);
    $display("Input stalled for %0d cycles; %0d mismatches.", input_stalls, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
